// ----- sv/assert_macros.svh -----
// Assertion macros shared by the attitude controller modules.
// No dependencies; included by every RTL file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LQI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LQI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The condition must never be true.
`define LQI_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- sv/lqi_pkg.sv -----
// Shared types, constants and the default gain table of the attitude controller.
// No dependencies; used by lqi_ctrl, lqi_datapath and lqi_attitude_controller.
package lqi_pkg;

    localparam int GAIN_W      = 18;
    localparam int TABLE_DEPTH = 36;
    localparam int IDX_W       = 6;
    localparam int KP_BASE     = 27;
    localparam int DT_W        = 16;
    localparam int DT_SHIFT    = 16;
    localparam int OUT_SHIFT   = 10;
    localparam int DRIVE_MAX   = 16384;
    localparam int DRIVE_W     = 16;
    localparam int LIMIT_W     = 15;
    localparam int CFG_ADDR_W  = 1;
    localparam int NUM_AXES    = 3;
    localparam int MAT_COLS    = 9;
    localparam int ROW_W       = 2;
    localparam int TERM_W      = 4;
    localparam int XSEL_W      = 4;
    localparam int X_RATE_BASE = 3;
    localparam int X_ACC_BASE  = 6;
    localparam int LIMIT_RESET = 4096;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MODE  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_addr;

    typedef enum logic {
        MODE_DECOUPLED = 1'b0,
        MODE_COUPLED   = 1'b1
    } t_mode;

    // Kind of an input item, carried in tuser.
    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_GAIN   = 1'b1
    } t_item_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INT_MUL,
        ST_INT_ACC,
        ST_MAC,
        ST_DRAIN,
        ST_OUT
    } t_lqi_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              sample_load;
        logic              gain_write;
        logic              int_mul;
        logic              int_acc;
        logic [ROW_W-1:0]  axis;
        logic              mac_issue;
        logic [ROW_W-1:0]  row;
        logic [TERM_W-1:0] term;
        logic              first;
        logic              last;
        logic              load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic  pipe_busy;
        logic  out_free;
        t_mode mode;
    } t_dp_status;

    // Gain table contents after reset, signed Q6.12.
    function automatic logic signed [GAIN_W-1:0] default_gain(input logic [IDX_W-1:0] idx);
        logic signed [GAIN_W-1:0] g;
        unique case (idx)
            6'd0:  g = 18'sd2867;
            6'd1:  g = 18'sd410;
            6'd2:  g = 18'sd0;
            6'd3:  g = 18'sd1229;
            6'd4:  g = 18'sd205;
            6'd5:  g = 18'sd0;
            6'd6:  g = 18'sd819;
            6'd7:  g = 18'sd82;
            6'd8:  g = 18'sd0;
            6'd9:  g = 18'sd410;
            6'd10: g = 18'sd2867;
            6'd11: g = 18'sd0;
            6'd12: g = 18'sd205;
            6'd13: g = 18'sd1229;
            6'd14: g = 18'sd0;
            6'd15: g = 18'sd82;
            6'd16: g = 18'sd819;
            6'd17: g = 18'sd0;
            6'd18: g = 18'sd0;
            6'd19: g = 18'sd0;
            6'd20: g = 18'sd2048;
            6'd21: g = 18'sd0;
            6'd22: g = 18'sd0;
            6'd23: g = 18'sd819;
            6'd24: g = 18'sd0;
            6'd25: g = 18'sd0;
            6'd26: g = 18'sd410;
            6'd27: g = 18'sd118338;
            6'd28: g = 18'sd43264;
            6'd29: g = 18'sd129527;
            6'd30: g = 18'sd118338;
            6'd31: g = 18'sd43264;
            6'd32: g = 18'sd129527;
            6'd33: g = 18'sd12288;
            6'd34: g = 18'sd3277;
            6'd35: g = 18'sd4096;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ----- sv/lqi_ctrl.sv -----
// Sequencing state machine of the attitude controller.
// Depends on lqi_pkg and assert_macros.svh; drives the command struct of lqi_datapath.
`include "assert_macros.svh"

module lqi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tuser,
    output logic                o_s_tready,
    input  lqi_pkg::t_dp_status i_status,
    output lqi_pkg::t_dp_cmd    o_cmd
);
    import lqi_pkg::*;

    t_lqi_state        r_state;
    t_lqi_state        n_state;
    logic [ROW_W-1:0]  r_axis;
    logic [ROW_W-1:0]  r_row;
    logic [TERM_W-1:0] r_term;
    logic [TERM_W-1:0] last_term;
    logic              term_last;
    logic              row_last;

    // Decoupled rows have three terms, coupled rows nine.
    assign last_term = (i_status.mode == MODE_COUPLED) ? TERM_W'(MAT_COLS - 1)
                                                       : TERM_W'(NUM_AXES - 1);
    assign term_last = (r_term == last_term);
    assign row_last  = (r_row == ROW_W'(NUM_AXES - 1));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && (i_s_tuser == CMD_SAMPLE)) begin
                    n_state = ST_INT_MUL;
                end
            end
            ST_INT_MUL: n_state = ST_INT_ACC;
            ST_INT_ACC: begin
                if (r_axis == ROW_W'(NUM_AXES - 1)) begin
                    n_state = ST_MAC;
                end else begin
                    n_state = ST_INT_MUL;
                end
            end
            ST_MAC: begin
                if (row_last && term_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Command outputs.
    always_comb begin
        o_s_tready        = (r_state == ST_IDLE);
        o_cmd             = '0;
        o_cmd.sample_load = (r_state == ST_IDLE) && i_s_tvalid && (i_s_tuser == CMD_SAMPLE);
        o_cmd.gain_write  = (r_state == ST_IDLE) && i_s_tvalid && (i_s_tuser == CMD_GAIN);
        o_cmd.int_mul     = (r_state == ST_INT_MUL);
        o_cmd.int_acc     = (r_state == ST_INT_ACC);
        o_cmd.axis        = r_axis;
        o_cmd.mac_issue   = (r_state == ST_MAC);
        o_cmd.row         = r_row;
        o_cmd.term        = r_term;
        o_cmd.first       = (r_term == '0);
        o_cmd.last        = term_last;
        o_cmd.load_out    = (r_state == ST_OUT) && i_status.out_free;
    end

    // State register and the axis, row and term counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_axis  <= '0;
            r_row   <= '0;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    r_axis <= '0;
                    r_row  <= '0;
                    r_term <= '0;
                end
                ST_INT_ACC: r_axis <= ROW_W'(r_axis + 1'b1);
                ST_MAC: begin
                    if (term_last) begin
                        r_term <= '0;
                        r_row  <= ROW_W'(r_row + 1'b1);
                    end else begin
                        r_term <= TERM_W'(r_term + 1'b1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    `LQI_ASSERT_IMP(a_out_after_drain, i_clk, i_rst_n, r_state == ST_OUT, !i_status.pipe_busy, "result released before the product pipeline drained")
    `LQI_ASSERT_NXT(a_mac_to_drain, i_clk, i_rst_n, r_state == ST_MAC && row_last && term_last, r_state == ST_DRAIN && i_status.pipe_busy, "last term issued but pipeline not busy in drain")
    `LQI_ASSERT_IMP(a_term_range, i_clk, i_rst_n, o_cmd.mac_issue, r_row < ROW_W'(NUM_AXES) && r_term <= TERM_W'(MAT_COLS - 1), "term issued outside the gain matrix")

endmodule

// ----- sv/lqi_datapath.sv -----
// Datapath of the attitude controller: registers, gain memory, shared multiplier,
// integrators, accumulator and output register. Depends on lqi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lqi_datapath #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int IN_W         = 136,
    parameter int OUT_W        = 96
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [IN_W-1:0]                i_s_tdata,
    input  logic                           i_cfg_valid,
    input  logic [lqi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lqi_pkg::LIMIT_W-1:0]    i_cfg_data,
    input  lqi_pkg::t_dp_cmd               i_cmd,
    output lqi_pkg::t_dp_status            o_status,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [OUT_W-1:0]               o_m_tdata
);
    import lqi_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int PROD_W = GAIN_W + SW;
    localparam int SUM_W  = PROD_W + 4;
    localparam int INT_W  = SW + 5;
    localparam int RND_W  = PROD_W - DT_SHIFT;
    localparam int FIN_W  = SUM_W - OUT_SHIFT;
    localparam int DT_OFF = 6 * SW;
    localparam int IX_OFF = DT_OFF + DT_W;
    localparam int GV_OFF = IX_OFF + IDX_W;
    localparam int IO_OFF = NUM_AXES * DRIVE_W;

    localparam logic signed [FIN_W-1:0] FIN_MAX  = FIN_W'(DRIVE_MAX);
    localparam logic signed [FIN_W-1:0] FIN_MIN  = -FIN_W'(DRIVE_MAX);
    localparam logic signed [INT_W-1:0] SMP_MAX  = INT_W'((1 << (SW - 1)) - 1);
    localparam logic signed [INT_W-1:0] SMP_MIN  = -INT_W'(1 << (SW - 1));
    localparam logic signed [PROD_W-1:0] RND_DT  = PROD_W'(1 << (DT_SHIFT - 1));
    localparam logic signed [SUM_W-1:0]  RND_OUT = SUM_W'(1 << (OUT_SHIFT - 1));

    // Configuration registers.
    t_mode                r_mode;
    logic [LIMIT_W-1:0]   r_limit;
    logic signed [LIMIT_W:0] lim_s;

    // Sample and integrator registers.
    logic signed [SW-1:0] r_err  [NUM_AXES];
    logic signed [SW-1:0] r_rate [NUM_AXES];
    logic signed [SW-1:0] r_acc  [NUM_AXES];
    logic [DT_W-1:0]      r_dt;

    // Gain memory with per-entry written flags.
    logic signed [GAIN_W-1:0] r_gain_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_gain_vld;
    logic [IDX_W-1:0]         wr_idx;
    logic [IDX_W-1:0]         rd_addr;
    logic [XSEL_W-1:0]        xsel;

    // Stage 1: read data and term tags.
    logic signed [GAIN_W-1:0] r_rd_gain;
    logic signed [GAIN_W-1:0] r_rd_dflt;
    logic                     r_rd_vld;
    logic                     r_p1_valid;
    logic [ROW_W-1:0]         r_p1_row;
    logic [XSEL_W-1:0]        r_p1_xsel;
    logic                     r_p1_first;
    logic                     r_p1_last;

    // Stage 2: product and tags.
    logic signed [GAIN_W-1:0] mul_a;
    logic signed [SW-1:0]     mul_b;
    logic signed [SW-1:0]     xval;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_p2_valid;
    logic [ROW_W-1:0]         r_p2_row;
    logic                     r_p2_first;
    logic                     r_p2_last;

    // Stage 3: row sum, finished into a drive.
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  prod_ext;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     r_p3_valid;
    logic [ROW_W-1:0]         r_p3_row;
    logic signed [SUM_W-1:0]  fin_t;
    logic signed [FIN_W-1:0]  fin_s;
    logic signed [DRIVE_W-1:0] fin_drive;
    logic signed [DRIVE_W-1:0] r_drive [NUM_AXES];

    // Integrator update.
    logic signed [PROD_W-1:0] rnd_t;
    logic signed [RND_W-1:0]  rnd;
    logic signed [INT_W-1:0]  int_sum;
    logic signed [INT_W-1:0]  int_lim;
    logic signed [INT_W-1:0]  int_clamp;
    logic signed [INT_W-1:0]  int_sat;
    logic signed [SW-1:0]     n_acc;

    // Output register.
    logic                     r_out_valid;
    logic [OUT_W-1:0]         r_out_data;
    logic [OUT_W-1:0]         n_out_data;

    assign lim_s = signed'({1'b0, r_limit});

    // Configuration writes; a mode write also clears the integrators.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_DECOUPLED;
            r_limit <= LIMIT_W'(LIMIT_RESET);
            for (int k = 0; k < NUM_AXES; k++) begin
                r_acc[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_addr'(i_cfg_addr))
                    CFG_MODE: begin
                        r_mode <= t_mode'(i_cfg_data[0]);
                        for (int k = 0; k < NUM_AXES; k++) begin
                            r_acc[k] <= '0;
                        end
                    end
                    CFG_LIMIT: r_limit <= i_cfg_data;
                    default: begin
                    end
                endcase
            end else if (i_cmd.int_acc) begin
                r_acc[i_cmd.axis] <= n_acc;
            end
        end
    end

    // Capture the sample fields of an accepted control sample.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample_load) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_err[k]  <= i_s_tdata[k * SW +: SW];
                r_rate[k] <= i_s_tdata[(k + NUM_AXES) * SW +: SW];
            end
            r_dt <= i_s_tdata[DT_OFF +: DT_W];
        end
    end

    // Gain memory write port.
    assign wr_idx = i_s_tdata[IX_OFF +: IDX_W];

    always_ff @(posedge i_clk) begin
        if (i_cmd.gain_write && (wr_idx < IDX_W'(TABLE_DEPTH))) begin
            r_gain_mem[wr_idx] <= i_s_tdata[GV_OFF +: GAIN_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_vld <= '0;
        end else if (i_cmd.gain_write && (wr_idx < IDX_W'(TABLE_DEPTH))) begin
            r_gain_vld[wr_idx] <= 1'b1;
        end
    end

    // Table address and state-vector element for the issued term.
    always_comb begin
        if (r_mode == MODE_COUPLED) begin
            rd_addr = IDX_W'(i_cmd.row) * IDX_W'(MAT_COLS) + IDX_W'(i_cmd.term);
            xsel    = XSEL_W'(i_cmd.term);
        end else begin
            rd_addr = IDX_W'(KP_BASE) + IDX_W'(i_cmd.row) * IDX_W'(NUM_AXES)
                    + IDX_W'(i_cmd.term);
            xsel    = XSEL_W'(i_cmd.row) + XSEL_W'(i_cmd.term) * XSEL_W'(NUM_AXES);
        end
    end

    // Stage 1: registered memory read, default value and tags.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_issue) begin
            r_rd_gain <= r_gain_mem[rd_addr];
            r_rd_vld  <= r_gain_vld[rd_addr];
            r_rd_dflt <= default_gain(rd_addr);
            r_p1_row  <= i_cmd.row;
            r_p1_xsel <= xsel;
            r_p1_first <= i_cmd.first;
            r_p1_last  <= i_cmd.last;
        end
    end

    // Element of the augmented state vector.
    always_comb begin
        priority if (r_p1_xsel < XSEL_W'(X_RATE_BASE)) begin
            xval = r_err[ROW_W'(r_p1_xsel)];
        end else if (r_p1_xsel < XSEL_W'(X_ACC_BASE)) begin
            xval = r_rate[ROW_W'(r_p1_xsel - XSEL_W'(X_RATE_BASE))];
        end else begin
            xval = r_acc[ROW_W'(r_p1_xsel - XSEL_W'(X_ACC_BASE))];
        end
    end

    // Shared multiplier: error times step time, or gain times state element.
    always_comb begin
        if (i_cmd.int_mul) begin
            mul_a = signed'({{(GAIN_W - DT_W){1'b0}}, r_dt});
            mul_b = r_err[i_cmd.axis];
        end else begin
            mul_a = r_rd_vld ? r_rd_gain : r_rd_dflt;
            mul_b = xval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.int_mul || r_p1_valid) begin
            r_prod <= mul_a * mul_b;
        end
        if (r_p1_valid) begin
            r_p2_row   <= r_p1_row;
            r_p2_first <= r_p1_first;
            r_p2_last  <= r_p1_last;
        end
    end

    // Integrator: round the product to Q3.12, add, clamp to the limit and the sample range.
    always_comb begin
        rnd_t   = r_prod + RND_DT;
        rnd     = rnd_t[PROD_W-1:DT_SHIFT];
        int_sum = INT_W'(r_acc[i_cmd.axis]) + INT_W'(rnd);
        int_lim = INT_W'(lim_s);
        priority if (int_sum > int_lim) begin
            int_clamp = int_lim;
        end else if (int_sum < -int_lim) begin
            int_clamp = -int_lim;
        end else begin
            int_clamp = int_sum;
        end
        priority if (int_clamp > SMP_MAX) begin
            int_sat = SMP_MAX;
        end else if (int_clamp < SMP_MIN) begin
            int_sat = SMP_MIN;
        end else begin
            int_sat = int_clamp;
        end
        n_acc = int_sat[SW-1:0];
    end

    // Stage 2 accumulate; coupled mode subtracts each product.
    always_comb begin
        prod_ext = SUM_W'(r_prod);
        if (r_mode == MODE_COUPLED) begin
            n_sum = (r_p2_first ? '0 : r_sum) - prod_ext;
        end else begin
            n_sum = (r_p2_first ? '0 : r_sum) + prod_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p2_valid) begin
            r_sum    <= n_sum;
            r_p3_row <= r_p2_row;
        end
    end

    // Stage 3: round the row sum to Q1.14 and saturate to plus or minus one.
    always_comb begin
        fin_t = r_sum + RND_OUT;
        fin_s = fin_t[SUM_W-1:OUT_SHIFT];
        priority if (fin_s > FIN_MAX) begin
            fin_drive = DRIVE_W'(FIN_MAX);
        end else if (fin_s < FIN_MIN) begin
            fin_drive = DRIVE_W'(FIN_MIN);
        end else begin
            fin_drive = fin_s[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p3_valid) begin
            r_drive[r_p3_row] <= fin_drive;
        end
    end

    // Pipeline valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else begin
            r_p1_valid <= i_cmd.mac_issue;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid && r_p2_last;
        end
    end

    // Result packing: drives, then integrators, zero padding on top.
    always_comb begin
        n_out_data = '0;
        for (int k = 0; k < NUM_AXES; k++) begin
            n_out_data[k * DRIVE_W +: DRIVE_W] = r_drive[k];
            n_out_data[IO_OFF + k * SW +: SW]  = r_acc[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= n_out_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    assign o_status.pipe_busy = r_p1_valid || r_p2_valid || r_p3_valid;
    assign o_status.out_free  = !r_out_valid || i_m_tready;
    assign o_status.mode      = r_mode;

    `LQI_ASSERT_NEVER(a_one_mul_src, i_clk, i_rst_n, i_cmd.int_mul && r_p1_valid, "integrator and matrix term share the multiplier in one cycle")
    `LQI_ASSERT_NEVER(a_write_during_mac, i_clk, i_rst_n, i_cmd.gain_write && (i_cmd.mac_issue || r_p1_valid), "gain table written while terms are read")
    `LQI_ASSERT_NXT(a_acc_limit, i_clk, i_rst_n, i_cmd.int_acc && !i_cfg_valid, r_acc[$past(i_cmd.axis)] <= lim_s && r_acc[$past(i_cmd.axis)] >= -lim_s, "integrator outside its limit after update")

endmodule

// ----- sv/lqi_attitude_controller.sv -----
// Top level of the three-axis LQI attitude controller.
// Depends on lqi_pkg, lqi_ctrl and lqi_datapath.

// A control sample (tuser low) is accepted and then passes these steps: per axis an
// integrator multiply and an integrator update, one gain term per cycle (27 in coupled
// mode, 9 in decoupled mode) through the single shared gain-by-state multiplier, a drain
// of its read, multiply and accumulate stages, and a load of the output register, which
// waits if the previous result has not been taken. The block is ready again in the cycle
// after that load, so a control sample sent back to back is accepted only after the
// previous result has been loaded. A gain write (tuser high) gives no result. Configuration
// writes are always accepted and must only be issued while the block is idle.
module lqi_attitude_controller #(
    parameter int  SAMPLE_WIDTH = 16,
    localparam int IN_W  = ((6 * SAMPLE_WIDTH + 40 + 7) / 8) * 8,
    localparam int OUT_W = ((48 + 3 * SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata, from bit 0: roll_err, pitch_err, yaw_err, roll_rate, pitch_rate,
    // yaw_rate, step_time, gain_index, gain_value, zero padding.
    input  logic [IN_W-1:0]                s_axis_tdata,
    // tuser: cmd.
    input  logic                           s_axis_tuser,
    // Result stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // tdata, from bit 0: roll_drive, pitch_drive, yaw_drive, roll_integral,
    // pitch_integral, yaw_integral, zero padding.
    output logic [OUT_W-1:0]               m_axis_tdata,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lqi_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [lqi_pkg::LIMIT_W-1:0]    i_cfg_data
);
    import lqi_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       cfg_wr;

    // Configuration registers take a write in any cycle.
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    lqi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tuser  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd)
    );

    lqi_datapath #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .IN_W         (IN_W),
        .OUT_W        (OUT_W)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_valid (cfg_wr),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (dp_cmd),
        .o_status    (dp_status),
        .i_m_tready  (m_axis_tready),
        .o_m_tvalid  (m_axis_tvalid),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

// ----- tb/sv/lqi_attitude_controller_tb.sv -----
// Self-checking testbench for the three-axis LQI attitude controller.
// Depends on lqi_pkg and lqi_attitude_controller; predicts every result transaction
// and checks it field by field against the result stream.
`timescale 1ns / 1ps

module lqi_attitude_controller_tb;

    import lqi_pkg::*;

    // Input item, packed as tdata: first field in the lowest bits.
    typedef struct packed {
        logic signed [17:0] gain_value;
        logic [5:0]         gain_index;
        logic [15:0]        step_time;
        logic signed [15:0] yaw_rate;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] roll_rate;
        logic signed [15:0] yaw_err;
        logic signed [15:0] pitch_err;
        logic signed [15:0] roll_err;
    } t_sample_word;

    // Result item, packed as tdata: first field in the lowest bits.
    typedef struct packed {
        logic signed [15:0] yaw_integral;
        logic signed [15:0] pitch_integral;
        logic signed [15:0] roll_integral;
        logic signed [15:0] yaw_drive;
        logic signed [15:0] pitch_drive;
        logic signed [15:0] roll_drive;
    } t_drive_word;

    // One row of the directed stimulus: a register write or an input item.
    typedef struct {
        bit           is_cfg;
        t_cfg_addr    reg_addr;
        logic [14:0]  reg_data;
        t_item_kind   kind;
        t_sample_word word;
        bit           typed;
        t_drive_word  want;
    } t_stim_row;

    localparam int IN_BITS      = $bits(t_sample_word);
    localparam int OUT_BITS     = $bits(t_drive_word);
    localparam int GAIN_ENTRIES = 36;
    localparam int PID_BASE     = 27;
    localparam int STEP_SHIFT   = 16;
    localparam int DRIVE_SHIFT  = 10;
    localparam int DRIVE_SAT    = 16384;
    localparam int SETTLE_CYCLES = 48;
    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 250;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata;
    logic                s_axis_tuser;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [LIMIT_W-1:0]  i_cfg_data;

    // Mirror of the controller state.
    t_mode mode_q = MODE_DECOUPLED;
    int    limit_q = 4096;
    int    integ [3] = '{0, 0, 0};
    int    gain_mem [GAIN_ENTRIES] = '{
        2867, 410, 0, 1229, 205, 0, 819, 82, 0,
        410, 2867, 0, 205, 1229, 0, 82, 819, 0,
        0, 0, 2048, 0, 0, 819, 0, 0, 410,
        118338, 43264, 129527,
        118338, 43264, 129527,
        12288, 3277, 4096
    };

    t_drive_word pending_drives [$];
    t_stim_row   stim_table [$];
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int          gap_pct = 0;
    int          stall_pct = 0;
    string       field_names [6] = '{"roll_drive", "pitch_drive", "yaw_drive",
                                     "roll_integral", "pitch_integral", "yaw_integral"};

    lqi_attitude_controller u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Shift right with rounding half toward plus infinity.
    function automatic longint round_half_up(input longint v, input int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Integrator update and drive law for one input item.
    function automatic void compute_drives(input t_item_kind kind, input t_sample_word w,
                                           output bit produced, output t_drive_word res);
        longint x [9];
        longint sum;
        longint drv [3];
        int a, k;
        produced = 1'b0;
        res = '0;
        if (kind == CMD_GAIN) begin
            if (w.gain_index < GAIN_ENTRIES)
                gain_mem[w.gain_index] = w.gain_value;
            return;
        end
        x[0] = w.roll_err;
        x[1] = w.pitch_err;
        x[2] = w.yaw_err;
        x[3] = w.roll_rate;
        x[4] = w.pitch_rate;
        x[5] = w.yaw_rate;
        // Integrate each error over the step, bounded by the limit, then the word range.
        for (a = 0; a < 3; a++) begin
            integ[a] = int'(clip(clip(integ[a]
                + round_half_up(x[a] * longint'(w.step_time), STEP_SHIFT),
                -limit_q, limit_q), -32768, 32767));
            x[6 + a] = integ[a];
        end
        for (a = 0; a < 3; a++) begin
            sum = 0;
            if (mode_q == MODE_DECOUPLED) begin
                sum = longint'(gain_mem[PID_BASE + 3 * a]) * x[a]
                    + longint'(gain_mem[PID_BASE + 3 * a + 1]) * x[3 + a]
                    + longint'(gain_mem[PID_BASE + 3 * a + 2]) * x[6 + a];
            end else begin
                for (k = 0; k < 9; k++)
                    sum -= longint'(gain_mem[9 * a + k]) * x[k];
            end
            drv[a] = clip(round_half_up(sum, DRIVE_SHIFT), -DRIVE_SAT, DRIVE_SAT);
        end
        res.roll_drive     = 16'(drv[0]);
        res.pitch_drive    = 16'(drv[1]);
        res.yaw_drive      = 16'(drv[2]);
        res.roll_integral  = 16'(integ[0]);
        res.pitch_integral = 16'(integ[1]);
        res.yaw_integral   = 16'(integ[2]);
        produced = 1'b1;
    endfunction

    // Register side effects; a mode write also clears the integrators.
    function automatic void apply_register(input t_cfg_addr a, input logic [14:0] d);
        case (a)
            CFG_MODE: begin
                mode_q = t_mode'(d[0]);
                integ = '{0, 0, 0};
            end
            CFG_LIMIT: limit_q = d;
            default: ;
        endcase
    endfunction

    function automatic t_sample_word pack_sample(input int re, input int pe, input int ye,
                                                 input int rr, input int pr, input int yr,
                                                 input int dt);
        t_sample_word w;
        // Unused gain fields are left all ones; the block must ignore them.
        w = '1;
        w.roll_err   = 16'(re);
        w.pitch_err  = 16'(pe);
        w.yaw_err    = 16'(ye);
        w.roll_rate  = 16'(rr);
        w.pitch_rate = 16'(pr);
        w.yaw_rate   = 16'(yr);
        w.step_time  = 16'(dt);
        return w;
    endfunction

    function automatic t_sample_word gain_word(input int idx, input int val);
        t_sample_word w;
        w = '1;
        w.gain_index = 6'(idx);
        w.gain_value = 18'(val);
        return w;
    endfunction

    function automatic t_drive_word result_word(input int rd, input int pd, input int yd,
                                                input int ri, input int pi, input int yi);
        t_drive_word r;
        r.roll_drive     = 16'(rd);
        r.pitch_drive    = 16'(pd);
        r.yaw_drive      = 16'(yd);
        r.roll_integral  = 16'(ri);
        r.pitch_integral = 16'(pi);
        r.yaw_integral   = 16'(yi);
        return r;
    endfunction

    function automatic void table_item(input t_item_kind kind, input t_sample_word w,
                                       input bit typed, input t_drive_word want);
        t_stim_row row;
        row.is_cfg   = 1'b0;
        row.reg_addr = CFG_MODE;
        row.reg_data = '0;
        row.kind     = kind;
        row.word     = w;
        row.typed    = typed;
        row.want     = want;
        stim_table.push_back(row);
    endfunction

    function automatic void table_cfg(input t_cfg_addr a, input int d);
        t_stim_row row;
        row.is_cfg   = 1'b1;
        row.reg_addr = a;
        row.reg_data = 15'(d);
        row.kind     = CMD_SAMPLE;
        row.word     = '0;
        row.typed    = 1'b0;
        row.want     = '0;
        stim_table.push_back(row);
    endfunction

    // Random magnitude spread over all scales so both small and saturating values occur.
    function automatic logic signed [15:0] scaled_sample();
        logic signed [15:0] r;
        r = 16'($urandom);
        return r >>> $urandom_range(0, 15);
    endfunction

    function automatic t_sample_word random_item(input t_item_kind kind);
        t_sample_word w;
        logic signed [17:0] g;
        w.roll_err   = scaled_sample();
        w.pitch_err  = scaled_sample();
        w.yaw_err    = scaled_sample();
        w.roll_rate  = scaled_sample();
        w.pitch_rate = scaled_sample();
        w.yaw_rate   = scaled_sample();
        w.step_time  = ($urandom_range(0, 2) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 4095));
        w.gain_index = 6'($urandom);
        w.gain_value = 18'($urandom);
        if (kind == CMD_GAIN) begin
            g = 18'($urandom);
            w.gain_value = g >>> $urandom_range(0, 17);
            // Mostly valid table entries, sometimes an index past the table.
            w.gain_index = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(36, 63))
                                                       : 6'($urandom_range(0, 35));
        end
        return w;
    endfunction

    // Offer one input transaction, then predict its result once it is accepted.
    task automatic push_item(input t_item_kind kind, input t_sample_word w,
                             input bit typed, input t_drive_word want);
        bit produced;
        t_drive_word res;
        if ($urandom_range(0, 99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= w;
        do @(posedge i_clk); while (!s_axis_tready);
        compute_drives(kind, w, produced, res);
        if (produced)
            pending_drives.push_back(typed ? want : res);
    endtask

    // Hold the input until every predicted result has been delivered.
    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_drives.size() != 0);
    endtask

    // Drained and settled: a trailing gain write may still be in flight otherwise.
    task automatic wait_idle();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_addr a, input logic [14:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(a, d);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Result side: random back-pressure bursts.
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if ($urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest prediction.
    always @(posedge i_clk) begin
        t_drive_word want;
        int fld;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_drives.size() == 0) begin
                $error("Result transaction with no prediction waiting: %h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_drives.pop_front();
                for (fld = 0; fld < 6; fld++) begin
                    if (m_axis_tdata[16 * fld +: 16] !== want[16 * fld +: 16]) begin
                        $error("%s: expected %0d, got %0d", field_names[fld],
                               $signed(want[16 * fld +: 16]),
                               $signed(m_axis_tdata[16 * fld +: 16]));
                        mismatch_count++;
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        t_stim_row    row;
        t_item_kind   kind;
        int           phase;
        int           n;
        logic [14:0]  limit_val;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= CMD_SAMPLE;
        i_cfg_valid   <= 1'b0;
        i_cfg_addr    <= CFG_MODE;
        i_cfg_data    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Decoupled defaults: zero input, then both extremes saturate every drive.
        table_item(CMD_SAMPLE, pack_sample(0, 0, 0, 0, 0, 0, 0), 1'b1,
                   result_word(0, 0, 0, 0, 0, 0));
        table_item(CMD_SAMPLE, pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535),
                   1'b1, result_word(16384, 16384, 16384, 4096, 4096, 4096));
        table_item(CMD_SAMPLE,
                   pack_sample(-32768, -32768, -32768, -32768, -32768, -32768, 65535),
                   1'b1, result_word(-16384, -16384, -16384, -4096, -4096, -4096));
        // Products that land exactly on a rounding half.
        table_item(CMD_SAMPLE, pack_sample(1, -1, 3, 0, 0, 0, 32768), 1'b0, '0);
        // Gain writes at the value extremes, and writes past the end of the table.
        table_item(CMD_GAIN, gain_word(27, 131071), 1'b0, '0);
        table_item(CMD_GAIN, gain_word(35, -131072), 1'b0, '0);
        table_item(CMD_GAIN, gain_word(36, 12345), 1'b0, '0);
        table_item(CMD_GAIN, gain_word(63, -1), 1'b0, '0);
        table_item(CMD_SAMPLE, pack_sample(500, -700, 900, -40, 60, -80, 2000), 1'b0, '0);
        // A zero limit pins the integrators at zero.
        table_cfg(CFG_LIMIT, 0);
        table_item(CMD_SAMPLE, pack_sample(32767, -32768, 1000, 10, -10, 5, 65535),
                   1'b0, '0);
        // Coupled matrix mode with the widest limit.
        table_cfg(CFG_MODE, 1);
        table_cfg(CFG_LIMIT, 32767);
        table_item(CMD_SAMPLE, pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535),
                   1'b1, result_word(-16384, -16384, -16384, 32767, 32767, 32767));
        table_item(CMD_SAMPLE, pack_sample(32767, 32767, 32767, 32767, 32767, 32767, 65535),
                   1'b1, result_word(-16384, -16384, -16384, 32767, 32767, 32767));
        table_item(CMD_SAMPLE, pack_sample(200, -150, 75, -300, 500, -20, 4000), 1'b0, '0);
        table_item(CMD_GAIN, gain_word(0, -131072), 1'b0, '0);
        table_item(CMD_GAIN, gain_word(26, 131071), 1'b0, '0);
        table_item(CMD_SAMPLE, pack_sample(-5, 7, -9, 11, -13, 15, 65535), 1'b0, '0);
        // Back to decoupled with the default limit.
        table_cfg(CFG_MODE, 0);
        table_cfg(CFG_LIMIT, 4096);
        table_item(CMD_SAMPLE, pack_sample(1, -1, 1, -1, 1, -1, 32768), 1'b0, '0);
        table_item(CMD_SAMPLE, pack_sample(-32768, 32767, 0, 32767, -32768, 0, 0), 1'b0, '0);

        gap_pct   = 20;
        stall_pct = 4;
        foreach (stim_table[r]) begin
            row = stim_table[r];
            if (row.is_cfg) begin
                wait_idle();
                write_reg(row.reg_addr, row.reg_data);
            end else begin
                push_item(row.kind, row.word, row.typed, row.want);
            end
        end

        // Random phases, each under a fresh register setting.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase % 4)
                0:       limit_val = 15'd0;
                1:       limit_val = 15'd32767;
                2:       limit_val = 15'd4096;
                default: limit_val = 15'($urandom);
            endcase
            write_reg(CFG_LIMIT, limit_val);
            write_reg(CFG_MODE, {14'($urandom), 1'(phase % 2)});
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
                case ($urandom_range(0, 2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 3;
                    default: stall_pct = 10;
                endcase
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                // The last phase runs without any pause on the input side.
                if (phase != PHASES - 1 && $urandom_range(0, 99) == 0)
                    wait_drain();
                kind = ($urandom_range(0, 6) == 0) ? CMD_GAIN : CMD_SAMPLE;
                push_item(kind, random_item(kind), 1'b0, '0);
            end
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_drives.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
